@@ rtl/core/itab_pkg.sv @@
// shared types, constants and character mapping for the integer to text converter
`default_nettype none

package itab_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGIT_W  = 6;
    localparam int CHAR_W   = 7;
    localparam int TDATA_W  = 8;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd10;

    localparam logic REG_RADIX = 1'b0;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_SHOW
    } itab_state_t;

    typedef struct packed {
        logic                wr_en;
        logic [DIGIT_W-1:0]  wr_digit;
    } itab_store_wr_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {1'b0, d};
        if (d > 6'd9)
        begin
            return CHAR_A - 7'd10 + ext;
        end
        return CHAR_ZERO + ext;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/itab_divider.sv @@
// bit-serial restoring divider: one quotient bit per cycle, small divisor
`default_nettype none

module itab_divider #(
    parameter int W = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [W-1:0]                  dividend,
    input  wire logic [itab_pkg::DIGIT_W-1:0]  divisor,
    output logic                               done,
    output logic [W-1:0]                       quotient,
    output logic [itab_pkg::DIGIT_W-1:0]       remainder
);
    import itab_pkg::*;

    localparam int CW = $clog2(W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [W-1:0]       quo_reg, quo_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;

    logic [DIGIT_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[W-2:0], fits};
            if (fits)
            begin
                rem_next = DIGIT_W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[DIGIT_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/core/itab_digits.sv @@
// digit store with registered read and digit to ascii mapping
`default_nettype none

module itab_digits #(
    parameter int DEPTH = 32
) (
    input  wire logic                          clk,
    input  wire itab_pkg::itab_store_wr_t      wr,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [itab_pkg::CHAR_W-1:0]        character
);
    import itab_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] rd_digit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            mem[wr_addr] <= wr.wr_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_digit_reg <= mem[rd_addr];
    end

    assign character = digit_char(rd_digit_reg);

endmodule

`default_nettype wire

@@ rtl/core/int_to_text_any_base_top.sv @@
// top level: apb radix register, conversion sequencer and character stream output
// conversion: each of the D digits takes one full pass of the bit-serial divider; then each
// character is read from the store and shown until m_tready high, a minus sign shown first
// throughput: one value at a time, s_tready high only when the previous text is fully sent
// reset: rst_n async active low; radix returns to 10, sequencer and divider go idle,
// digit store contents are left as they are
`default_nettype none

module int_to_text_any_base_top #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // apb configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [itab_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [itab_pkg::APB_W-1:0]    pwdata,
    output logic [itab_pkg::APB_W-1:0]         prdata,
    output logic                               pready,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [itab_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [itab_pkg::TDATA_W-1:0]       m_tdata,   // [6:0] character, [7] zero
    output logic                               m_tlast    // last_char
);
    import itab_pkg::*;

    localparam int IDX_W = $clog2(VALUE_BITS);

    itab_state_t         state_reg, state_next;
    logic [DIGIT_W-1:0]  radix_reg, radix_next;
    logic                neg_reg, neg_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;

    logic [VALUE_BITS+VALUE_W-1:0] ext;
    logic [VALUE_BITS-1:0]         raw;
    logic                          raw_neg;
    logic [VALUE_BITS-1:0]         raw_mag;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [DIGIT_W-1:0]    div_remainder;

    itab_store_wr_t        store_wr;
    logic [CHAR_W-1:0]     digit_ch;

    logic                  cfg_wr;
    logic [DIGIT_W-1:0]    cfg_val;
    logic                  in_xfer;
    logic                  finish;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_RADIX);
    assign cfg_val = pwdata[DIGIT_W-1:0];
    assign prdata  = (paddr[2] == REG_RADIX) ? {{(APB_W-DIGIT_W){1'b0}}, radix_reg} : '0;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_wr)
        begin
            if (cfg_val < RADIX_MIN)
            begin
                radix_next = RADIX_MIN;
            end
            else if (cfg_val > RADIX_MAX)
            begin
                radix_next = RADIX_MAX;
            end
            else
            begin
                radix_next = cfg_val;
            end
        end
    end

    // input value to sign and magnitude
    assign ext     = {{VALUE_BITS{1'b0}}, s_tdata};
    assign raw     = ext[VALUE_BITS-1:0];
    assign raw_neg = raw[VALUE_BITS-1];
    assign raw_mag = raw_neg ? VALUE_BITS'(~raw + 1'b1) : raw;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign finish = (div_quotient == '0) || (ptr_reg == IDX_W'(VALUE_BITS - 1));

    always_comb
    begin
        state_next        = state_reg;
        neg_next          = neg_reg;
        ptr_next          = ptr_reg;
        div_start         = 1'b0;
        div_dividend      = div_quotient;
        store_wr.wr_en    = 1'b0;
        store_wr.wr_digit = div_remainder;
        m_tvalid          = 1'b0;
        m_tlast           = 1'b0;
        m_tdata           = {1'b0, digit_ch};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next     = raw_neg;
                    ptr_next     = '0;
                    div_start    = 1'b1;
                    div_dividend = raw_mag;
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    store_wr.wr_en = 1'b1;
                    if (finish)
                    begin
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    end
                    else
                    begin
                        ptr_next  = ptr_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            ST_SIGN:
            begin
                m_tvalid = 1'b1;
                m_tdata  = {1'b0, CHAR_MINUS};
                if (m_tready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                m_tvalid = 1'b1;
                m_tlast  = (ptr_reg == '0);
                if (m_tready)
                begin
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_RESET;
            neg_reg   <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
            ptr_reg   <= ptr_next;
        end
    end

    itab_divider #(
        .W (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    itab_digits #(
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .clk       (clk),
        .wr        (store_wr),
        .wr_addr   (ptr_reg),
        .rd_addr   (ptr_reg),
        .character (digit_ch)
    );

endmodule

`default_nettype wire

@@ tb/tb_int_to_text_any_base_top.sv @@
// testbench for the integer to text converter: apb radix writes, value stream in, checked text out
`timescale 1ns / 100ps

module tb_int_to_text_any_base_top;

    import itab_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE_TIME  = 40;
    localparam int HOLD_OFF     = 500;
    localparam int ITEMS_PER_PHASE = 33;
    localparam logic [ADDR_W-1:0] RADIX_ADDR = {REG_RADIX, 2'b00};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [APB_W-1:0]     pwdata;
    logic [APB_W-1:0]     prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata;    // [31:0] value
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;    // [6:0] character, [7] zero
    logic                 m_tlast;

    text_char_t           text_q[$];
    text_char_t           text_head;
    logic [DIGIT_W-1:0]   radix_now;
    int                   mismatch_count;
    int                   values_sent;
    int                   chars_checked;
    int                   radix_settings;
    int                   input_stall_cycles;
    int                   hold_left;
    int                   longest_hold;
    int                   rx_gap_left;
    int                   cycle_count;
    bit                   tx_idle_en;
    bit                   rx_stall_en;

    int_to_text_any_base_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    task automatic note_mismatch(input string what, input logic [31:0] exp, input logic [31:0] act);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch on %s: expected %0h, actual %0h", what, exp, act);
        end
    endtask

    // expected text of one value in the current radix, most significant character first
    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        logic [DIGIT_W-1:0] digit_buf [VALUE_W];
        logic [VALUE_W-1:0] mag;
        logic [CHAR_W-1:0]  d7;
        text_char_t         c;
        int                 n;
        bit                 neg;
        neg = raw[VALUE_W-1];
        mag = neg ? (~raw + 1'b1) : raw;
        n = 0;
        do
        begin
            digit_buf[n] = DIGIT_W'(mag % VALUE_W'(radix_now));
            mag = mag / VALUE_W'(radix_now);
            n++;
        end
        while (mag != 0 && n < VALUE_W);
        if (neg)
        begin
            c.ch = CHAR_MINUS;
            c.last = 1'b0;
            text_q.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            d7 = {1'b0, digit_buf[i]};
            c.ch = (digit_buf[i] > 9) ? CHAR_A + d7 - 7'd10 : CHAR_ZERO + d7;
            c.last = (i == 0);
            text_q.push_back(c);
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        longint             p;
        int                 steps;
        case ($urandom_range(0, 7))
            0, 1:
            begin
                v = $urandom;
            end
            2:
            begin
                v = $urandom_range(0, 40);
            end
            3:
            begin
                v = -$urandom_range(1, 40);
            end
            4:
            begin
                v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                         : 32'h8000_0000 + $urandom_range(0, 3);
            end
            5:
            begin
                // near a power of the radix, where the digit count steps
                p = 1;
                steps = $urandom_range(1, 31);
                while (steps > 0 && p * radix_now <= 64'h7FFF_FFFF)
                begin
                    p = p * radix_now;
                    steps--;
                end
                v = VALUE_W'(p) - $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            default:
            begin
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic [APB_W-1:0] random_radix_word();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1);
            1: return $urandom_range(37, 63);
            2: return $urandom;
            default: return $urandom_range(2, 36);
        endcase
    endfunction

    task automatic write_radix(input logic [APB_W-1:0] word);
        logic [DIGIT_W-1:0] low;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RADIX_ADDR;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        low = word[DIGIT_W-1:0];
        radix_now = (low < RADIX_MIN) ? RADIX_MIN : ((low > RADIX_MAX) ? RADIX_MAX : low);
        radix_settings++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_radix();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= RADIX_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== APB_W'(radix_now))
        begin
            note_mismatch("radix readback", APB_W'(radix_now), prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // s_tvalid stays high after the transfer, the next call or stop_values decides
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        predict_text(v);
        values_sent++;
    endtask

    task automatic stop_values();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_text_done();
        stop_values();
        while (text_q.size() != 0) @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
    endtask

    task automatic test_default_radix();
        read_radix();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        wait_text_done();
    endtask

    task automatic test_radix_bounds();
        write_radix(32'd2);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h5555_5555);
        wait_text_done();
        write_radix(32'd36);
        read_radix();
        send_value(32'd35);
        send_value(32'd36);
        send_value(-32'sd1295);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        wait_text_done();
        write_radix(32'd16);
        send_value(32'hAAAA_AAAA);
        send_value(32'h1234_5678);
        wait_text_done();
    endtask

    task automatic test_radix_saturation();
        logic [APB_W-1:0] words [5];
        words = '{32'd0, 32'd1, 32'd37, 32'd63, 32'hFFFF_FFC1};
        foreach (words[i])
        begin
            write_radix(words[i]);
            read_radix();
            send_value(-32'sd123456789);
            wait_text_done();
        end
    endtask

    task automatic test_random_radices();
        for (int phase = 0; phase < 10; phase++)
        begin
            write_radix(random_radix_word());
            tx_idle_en  = (phase % 3 != 2);
            rx_stall_en = (phase % 4 != 3);
            repeat (ITEMS_PER_PHASE) send_value(random_value());
            wait_text_done();
        end
    endtask

    task automatic test_output_hold_off();
        write_radix(32'd10);
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        @(posedge clk);
        hold_left = HOLD_OFF;
        repeat (6) send_value(random_value());
        wait_text_done();
    endtask

    task automatic test_back_to_back();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        write_radix($urandom_range(2, 36));
        repeat (20) send_value(random_value());
        wait_text_done();
    endtask

    // receiver: random stall bursts plus the long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
            longest_hold++;
        end
        else if (rx_gap_left > 0)
        begin
            m_tready <= 1'b0;
            rx_gap_left--;
        end
        else if (rx_stall_en && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap_left = $urandom_range(1, 6) - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && !s_tready)
        begin
            input_stall_cycles++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (text_q.size() == 0)
            begin
                note_mismatch("character with nothing expected", 32'd0,
                              32'({m_tlast, m_tdata}));
            end
            else
            begin
                text_head = text_q.pop_front();
                if (m_tdata !== {1'b0, text_head.ch})
                begin
                    note_mismatch("character", 32'({1'b0, text_head.ch}), 32'(m_tdata));
                end
                if (m_tlast !== text_head.last)
                begin
                    note_mismatch("last flag", 32'(text_head.last), 32'(m_tlast));
                end
                chars_checked++;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        radix_now = RADIX_RESET;
        mismatch_count = 0;
        values_sent = 0;
        chars_checked = 0;
        radix_settings = 0;
        input_stall_cycles = 0;
        hold_left = 0;
        longest_hold = 0;
        rx_gap_left = 0;
        tx_idle_en = 1'b1;
        rx_stall_en = 1'b1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_default_radix();
        test_radix_bounds();
        test_radix_saturation();
        test_random_radices();
        test_output_hold_off();
        test_back_to_back();

        $display("converted %0d values under %0d radix writes, %0d characters checked",
                 values_sent, radix_settings, chars_checked);
        $display("output held off %0d cycles in total, input stalled %0d cycles with data waiting",
                 longest_hold, input_stall_cycles);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/itab_pkg.sv
rtl/core/itab_divider.sv
rtl/core/itab_digits.sv
rtl/core/int_to_text_any_base_top.sv
tb/tb_int_to_text_any_base_top.sv
